FILE: sv/swm_pkg.sv
package swm_pkg;

    // Sample and window length widths fixed by the stream format.
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 7;

    // Most negative sample, the neutral start value of a running maximum.
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Partial-maximum token that travels along the cell chain.
    typedef struct packed {
        logic                       vld;
        logic [LEN_W-1:0]           rem;
        logic signed [SAMPLE_W-1:0] acc;
        logic                       last;
    } t_tok;

endpackage

FILE: sv/swm_in_if.sv
interface swm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last_in;

    modport source (output valid, output sample, output last_in, input ready);
    modport sink   (input valid, input sample, input last_in, output ready);
endinterface

FILE: sv/swm_out_if.sv
interface swm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] window_max;
    logic               last_out;

    modport source (output valid, output window_max, output last_out, input ready);
    modport sink   (input valid, input window_max, input last_out, output ready);
endinterface

FILE: sv/swm_cell.sv
module swm_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic signed [15:0]   i_sample,
    output logic signed [15:0]   o_sample,
    input  logic                 i_adv,
    input  swm_pkg::t_tok        i_tok,
    output swm_pkg::t_tok        o_tok
);
    import swm_pkg::*;

    logic signed [SAMPLE_W-1:0] r_sample;
    t_tok                       r_tok;

    // The sample moves one place down the line when a new item arrives.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    // The token register takes the merged token of the previous cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_tok <= i_tok;
        end
    end

    // While the token still needs samples, fold this cell's sample into it.
    always_comb begin
        o_tok = r_tok;
        if (r_tok.vld && (r_tok.rem != '0)) begin
            o_tok.rem = r_tok.rem - 1'b1;
            if (r_sample > r_tok.acc) begin
                o_tok.acc = r_sample;
            end
        end
    end

    assign o_sample = r_sample;

endmodule

FILE: sv/sliding_window_max_core.sv
// Streaming maximum over the most recent window_len signed samples.
// Input channel i_in carries one sample and a last_in flag per item; output
// channel o_out carries window_max and last_out. Both use valid/ready, an item
// moving on a clock edge with both high. i_cfg_we/i_cfg_data write window_len
// (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW); the user must
// write it only while idle, which the block does not enforce. Samples sit in
// a shift line of MAX_WINDOW cells, newest first. A sample that completes a
// window launches a token that walks the chain one cell a cycle unless held,
// folding in one sample per cell until window_len samples are seen. An item
// that yields a result sends its token through all MAX_WINDOW cells into the
// output register before the result is offered; the next item is taken the
// cycle after the token leaves the chain. An item yielding no result (window
// not yet full) keeps the input ready. A last_in item resets the fill count.
// Reset sets window_len to 4, empties the chain and the output register.
// When the receiver stalls, the result waits in the output register and the
// token at the chain end holds until that register is free.
module sliding_window_max_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swm_in_if.sink      i_in,
    swm_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data
);
    import swm_pkg::*;

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);

    logic [LEN_W-1:0]           r_wl;
    logic [FILL_W-1:0]          r_fill;
    logic [FILL_W-1:0]          n_fill;
    logic                       r_busy;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_max;
    logic                       r_out_last;

    logic [LEN_W-1:0]           w_len;
    logic                       w_accept;
    logic                       w_produce;
    logic                       w_adv;
    logic                       w_done;
    t_tok                       w_tok [MAX_WINDOW+1];
    logic signed [SAMPLE_W-1:0] w_smp [MAX_WINDOW+1];

    // Window length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= LEN_W'(4);
        end else if (i_cfg_we) begin
            r_wl <= i_cfg_data;
        end
    end

    // Effective length, kept within one and the chain length.
    always_comb begin
        w_len = r_wl;
        if (r_wl == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_wl) > 32'(MAX_WINDOW)) begin
            w_len = LEN_W'(MAX_WINDOW);
        end
    end

    // Handshake and fill count of the current sequence.
    assign i_in.ready = !r_busy;
    assign w_accept   = i_in.valid && !r_busy;
    assign n_fill     = (r_fill < FILL_W'(MAX_WINDOW)) ? r_fill + 1'b1 : r_fill;
    assign w_produce  = 32'(n_fill) >= 32'(w_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= i_in.last_in ? '0 : n_fill;
        end
    end

    // Token launched into the first cell together with the new sample.
    always_comb begin
        w_tok[0].vld  = w_accept && w_produce;
        w_tok[0].rem  = w_len;
        w_tok[0].acc  = SAMPLE_MIN;
        w_tok[0].last = i_in.last_in;
    end
    assign w_smp[0] = i_in.sample;

    // The chain holds only when a finished token meets a full, stalled output.
    assign w_done = w_tok[MAX_WINDOW].vld;
    assign w_adv  = !(w_done && r_out_vld && !o_out.ready);

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
            swm_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_accept),
                .i_sample (w_smp[g]),
                .o_sample (w_smp[g+1]),
                .i_adv    (w_adv),
                .i_tok    (w_tok[g]),
                .o_tok    (w_tok[g+1])
            );
        end
    endgenerate

    // Busy from launching a token until it leaves the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept && w_produce) begin
            r_busy <= 1'b1;
        end else if (w_done && w_adv) begin
            r_busy <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_done && w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_adv) begin
            r_out_max  <= w_tok[MAX_WINDOW].acc;
            r_out_last <= w_tok[MAX_WINDOW].last;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.window_max = r_out_max;
    assign o_out.last_out   = r_out_last;

endmodule
